// ----- design/gmec_pkg.sv -----
package gmec_pkg;

	// fixed-point formats
	localparam int QW = 40;                  // saturating Q.24 value
	localparam int WW = 48;                  // unsaturated sums
	localparam int IFB = 24;                 // internal fraction bits
	localparam int DW = QW - 1;              // magnitude width
	localparam int NW = DW + IFB;            // dividend magnitude width
	localparam int KS = 54;                  // reciprocal scale of constant multipliers
	localparam int KCW = 57;                 // reciprocal width
	localparam int NGAS = 6;
	localparam int OW = 24;
	localparam int FRAC_BITS_DEF = 16;
	localparam int PCT_W = 23;

	localparam longint Milli = 1000;
	localparam longint TenK = 10000;

	typedef logic signed [QW-1:0] q_t;
	typedef logic signed [WW-1:0] wide_t;

	typedef struct packed {
		logic neg;
		logic [KCW-1:0] c;
	} kcoef_t;

	typedef struct packed {
		logic [PCT_W-1:0] co2_pct;
		logic [PCT_W-1:0] n2_pct;
		logic [PCT_W-1:0] o2_pct;
		logic [PCT_W-1:0] ch4_pct;
		logic [PCT_W-1:0] co_pct;
		logic [PCT_W-1:0] h2_pct;
		logic [PCT_W-1:0] c2h2_pct;
		logic [PCT_W-1:0] c2h4_pct;
		logic [PCT_W-1:0] c2h6_pct;
	} sample_t;

	typedef struct packed {
		logic explosive;
		logic signed [OW-1:0] x_coord;
		logic signed [OW-1:0] y_coord;
		logic fault;
	} verdict_t;

	localparam q_t SATQ = {1'b0, {DW{1'b1}}};
	localparam q_t ONEQ = q_t'(longint'(1) <<< IFB);

	// additive constant from thousandths, truncated
	function automatic q_t cq(int milli);
		longint t;
		t = (longint'(milli) <<< IFB) / Milli;
		return q_t'(t);
	endfunction

	// reciprocal multiplier for k/1000
	function automatic kcoef_t kc_milli(int k);
		logic [127:0] a;
		int ak;
		ak = (k < 0) ? -k : k;
		a = (128'(ak) << KS) + 128'(Milli - 1);
		a = a / 128'(Milli);
		return '{neg: (k < 0), c: a[KCW-1:0]};
	endfunction

	// reciprocal multiplier for k/10000
	function automatic kcoef_t kc_tenk(int k);
		logic [127:0] a;
		int ak;
		ak = (k < 0) ? -k : k;
		a = (128'(ak) << KS) + 128'(TenK - 1);
		a = a / 128'(TenK);
		return '{neg: (k < 0), c: a[KCW-1:0]};
	endfunction

	function automatic logic [DW-1:0] mag(q_t v);
		logic [QW-1:0] a;
		a = v[QW-1] ? QW'(-v) : QW'(v);
		return a[DW-1:0];
	endfunction

	function automatic q_t sat(wide_t v);
		if (v > wide_t'(SATQ)) begin
			return SATQ;
		end else if (v < -wide_t'(SATQ)) begin
			return -SATQ;
		end
		return v[QW-1:0];
	endfunction

	// v times constant, truncated toward zero, saturated
	function automatic q_t kmul(q_t v, kcoef_t k);
		logic [DW-1:0] m;
		logic [DW+KCW-1:0] p;
		logic [DW+KCW-KS-1:0] r;
		logic neg;
		m = mag(v);
		p = (DW+KCW)'(m) * (DW+KCW)'(k.c);
		r = p[DW+KCW-1:KS];
		neg = v[QW-1] ^ k.neg;
		if (r > (DW+KCW-KS)'(SATQ)) begin
			r = (DW+KCW-KS)'(SATQ);
		end
		return neg ? -q_t'(r) : q_t'(r);
	endfunction

	// front constants
	localparam q_t C_ALPHA_OFS = q_t'((longint'(3) <<< IFB) / 100);
	localparam q_t C_BETA_NUM = q_t'((longint'(2093) <<< IFB) / 100);
	localparam kcoef_t KC_O2 = kc_milli(3778);
	localparam kcoef_t KC_PT = kc_tenk(2093);

	// per-gas coefficient tables
	localparam q_t CQ_A [NGAS] = '{cq(10376), cq(13039), cq(14918), cq(15308),
		cq(14269), cq(11872)};
	localparam kcoef_t KC_B [NGAS] = '{kc_milli(3016), kc_milli(3396), kc_milli(3533),
		kc_milli(3577), kc_milli(3526), kc_milli(2909)};
	localparam q_t CQ_XC [NGAS] = '{cq(0), cq(3117), cq(4643), cq(4901), cq(4121),
		cq(1937)};
	localparam kcoef_t KC_XD [NGAS] = '{kc_milli(1000), kc_milli(167), kc_milli(140),
		kc_milli(127), kc_milli(385), kc_milli(1052)};
	localparam kcoef_t KC_XE [NGAS] = '{kc_milli(0), kc_milli(-7), kc_milli(-10),
		kc_milli(-11), kc_milli(-9), kc_milli(-5)};
	localparam kcoef_t KC_XF [NGAS] = '{kc_milli(-780), kc_milli(-400), kc_milli(-107),
		kc_milli(-45), kc_milli(-216), kc_milli(-724)};
	localparam q_t CQ_YC [NGAS] = '{cq(0), cq(3622), cq(5401), cq(5719), cq(4849),
		cq(2233)};
	localparam kcoef_t KC_YD [NGAS] = '{kc_milli(0), kc_milli(133), kc_milli(116),
		kc_milli(115), kc_milli(72), kc_milli(-37)};
	localparam kcoef_t KC_YE [NGAS] = '{kc_milli(1000), kc_milli(797), kc_milli(698),
		kc_milli(680), kc_milli(729), kc_milli(875)};
	localparam kcoef_t KC_YF [NGAS] = '{kc_milli(-2852), kc_milli(-2619), kc_milli(-2435),
		kc_milli(-2415), kc_milli(-2519), kc_milli(-2391)};

endpackage

// ----- design/gas_mixture_explosibility_check_core.sv -----
// Explosion-triangle check of one gas analysis per transfer. Nine Q7.FRAC_BITS volume
// percentages go in, and the verdict (explosive flag, X and Y in signed Q8.FRAC_BITS,
// fault flag) comes out. A new sample is taken every cycle unless the pipeline is held.
// It passes three chained 40-step restoring dividers (alpha, per-gas beta, per-gas term),
// each one quotient bit per stage, plus the front, multiplier and merge stages. Six
// lanes, one per combustible, work side by side and a merge stage sums their terms. The
// whole pipeline holds while a finished verdict waits to be taken. A zero divisor or zero
// combustible total gives fault set, explosive clear and both coordinates zero.
module gas_mixture_explosibility_check_core #(
	parameter int FRAC_BITS = gmec_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  gmec_pkg::sample_t   sample,
	output logic                verdict_valid,
	input  logic                verdict_ready,
	output gmec_pkg::verdict_t  verdict
);

	localparam int SH = gmec_pkg::IFB - FRAC_BITS;
	localparam int QW = gmec_pkg::QW;
	localparam int NGAS = gmec_pkg::NGAS;

	typedef struct packed {
		gmec_pkg::q_t o2;
		gmec_pkg::q_t pt;
		gmec_pkg::q_t [NGAS-1:0] gas;
		gmec_pkg::q_t bnum;
		logic flt;
	} atag_t;

	logic en;
	logic [NGAS-1:0][gmec_pkg::PCT_W-1:0] comb_pct;
	gmec_pkg::wide_t pt_sum;

	logic vld_s1, vld_s2;
	gmec_pkg::q_t co2_s1, n2_s1, o2_s1, pt_s1, ko2_s1;
	gmec_pkg::q_t [NGAS-1:0] gas_s1;
	gmec_pkg::q_t anum_s2, aden_s2, bnum_s2, o2_s2, pt_s2;
	gmec_pkg::q_t [NGAS-1:0] gas_s2;
	logic flt_s2;

	atag_t atag, alpha_tag;
	logic alpha_valid;
	gmec_pkg::q_t alpha;

	logic [NGAS-1:0] term_valid;
	logic [NGAS-1:0] term_fault;
	gmec_pkg::q_t term_x [NGAS];
	gmec_pkg::q_t term_y [NGAS];

	function automatic gmec_pkg::q_t widen(logic [gmec_pkg::PCT_W-1:0] v);
		return gmec_pkg::q_t'(QW'(v) << SH);
	endfunction

	// whole pipeline advances unless a verdict is stalled
	assign en = !verdict_valid || verdict_ready;
	assign sample_ready = en;

	assign comb_pct = {sample.c2h6_pct, sample.c2h4_pct, sample.c2h2_pct,
		sample.h2_pct, sample.co_pct, sample.ch4_pct};

	always_comb begin
		pt_sum = '0;
		for (int i = 0; i < NGAS; i++) begin
			pt_sum = pt_sum + gmec_pkg::wide_t'(widen(comb_pct[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample_valid;
			vld_s2 <= vld_s1;
		end
	end

	// front: scale inputs, total, alpha operands, beta numerator
	always_ff @(posedge clk) begin
		if (en) begin
			co2_s1 <= widen(sample.co2_pct);
			n2_s1 <= widen(sample.n2_pct);
			o2_s1 <= widen(sample.o2_pct);
			ko2_s1 <= gmec_pkg::kmul(widen(sample.o2_pct), gmec_pkg::KC_O2);
			pt_s1 <= gmec_pkg::sat(pt_sum);
			for (int i = 0; i < NGAS; i++) begin
				gas_s1[i] <= widen(comb_pct[i]);
			end

			anum_s2 <= gmec_pkg::sat(gmec_pkg::wide_t'(co2_s1)
				- gmec_pkg::wide_t'(gmec_pkg::C_ALPHA_OFS));
			aden_s2 <= gmec_pkg::sat(gmec_pkg::wide_t'(co2_s1) + gmec_pkg::wide_t'(n2_s1)
				- gmec_pkg::wide_t'(ko2_s1));
			bnum_s2 <= gmec_pkg::sat(gmec_pkg::wide_t'(gmec_pkg::C_BETA_NUM)
				- (gmec_pkg::wide_t'(o2_s1)
				+ gmec_pkg::wide_t'(gmec_pkg::kmul(pt_s1, gmec_pkg::KC_PT))));
			flt_s2 <= (pt_s1 == '0) || ((gmec_pkg::wide_t'(co2_s1) + gmec_pkg::wide_t'(n2_s1)
				- gmec_pkg::wide_t'(ko2_s1)) == '0);
			o2_s2 <= o2_s1;
			pt_s2 <= pt_s1;
			gas_s2 <= gas_s1;
		end
	end

	// alpha = (co2 - 0.03) / (co2 + n2 - 3.778 o2)
	assign atag = '{o2: o2_s2, pt: pt_s2, gas: gas_s2, bnum: bnum_s2, flt: flt_s2};

	gmec_div #(.TAG_W($bits(atag_t))) u_alpha_div (
		.clk(clk), .arst_n(arst_n), .en(en), .start(vld_s2),
		.num(anum_s2), .den(aden_s2), .tag(atag),
		.quo_valid(alpha_valid), .quo(alpha), .quo_tag(alpha_tag)
	);

	// one lane per combustible
	for (genvar g = 0; g < NGAS; g++) begin : g_lane
		gmec_lane #(.GAS(g)) u_lane (
			.clk(clk), .arst_n(arst_n), .en(en), .start(alpha_valid),
			.alpha(alpha), .bnum(alpha_tag.bnum), .pt(alpha_tag.pt), .o2(alpha_tag.o2),
			.gas(alpha_tag.gas[g]), .flt(alpha_tag.flt),
			.term_valid(term_valid[g]), .term_x(term_x[g]), .term_y(term_y[g]),
			.term_fault(term_fault[g])
		);
	end

	gmec_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
		.clk(clk), .arst_n(arst_n), .en(en), .start(&term_valid),
		.term_x(term_x), .term_y(term_y), .term_fault(term_fault),
		.verdict_valid(verdict_valid), .verdict(verdict)
	);

endmodule

// ----- design/gmec_div.sv -----
module gmec_div #(
	parameter int TAG_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                start,
	input  gmec_pkg::q_t        num,
	input  gmec_pkg::q_t        den,
	input  logic [TAG_W-1:0]    tag,
	output logic                quo_valid,
	output gmec_pkg::q_t        quo,
	output logic [TAG_W-1:0]    quo_tag
);

	localparam int QW = gmec_pkg::QW;
	localparam int DW = gmec_pkg::DW;
	localparam int NW = gmec_pkg::NW;
	localparam int STEPS = QW;

	logic             vld_s [0:STEPS-1];
	logic [NW-1:0]    rem_s [0:STEPS-1];
	logic [DW-1:0]    dv_s  [0:STEPS-1];
	logic [QW-1:0]    quo_s [0:STEPS-1];
	logic             neg_s [0:STEPS-1];
	logic             ovf_s [0:STEPS-1];
	logic [TAG_W-1:0] tag_s [0:STEPS-1];

	logic [NW-1:0] rem_nx [0:STEPS-1];
	logic [QW-1:0] quo_nx [0:STEPS-1];
	logic [NW+DW-1:0] sh;
	logic [NW+DW-1:0] rem_ext;
	logic [NW-1:0] nm0;
	logic [DW-1:0] dm0;
	logic [QW-1:0] qfin;

	// magnitude prep and overflow precheck
	assign nm0 = {gmec_pkg::mag(num), {gmec_pkg::IFB{1'b0}}};
	assign dm0 = gmec_pkg::mag(den);

	// one restoring step per stage
	always_comb begin
		sh = '0;
		rem_ext = '0;
		for (int j = 0; j < STEPS; j++) begin
			sh = {{NW{1'b0}}, dv_s[j]} << (STEPS - 1 - j);
			rem_ext = {{DW{1'b0}}, rem_s[j]};
			if (rem_ext >= sh) begin
				rem_nx[j] = NW'(rem_ext - sh);
				quo_nx[j] = quo_s[j] | (QW'(1) << (STEPS - 1 - j));
			end else begin
				rem_nx[j] = rem_s[j];
				quo_nx[j] = quo_s[j];
			end
		end
	end

	assign qfin = quo_nx[STEPS-1];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < STEPS; j++) begin
				vld_s[j] <= 1'b0;
			end
			quo_valid <= 1'b0;
		end else if (en) begin
			vld_s[0] <= start;
			for (int j = 1; j < STEPS; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
			quo_valid <= vld_s[STEPS-1];
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= nm0;
			dv_s[0]  <= dm0;
			quo_s[0] <= '0;
			neg_s[0] <= num[QW-1] ^ den[QW-1];
			ovf_s[0] <= (NW'(nm0 >> QW) >= NW'(dm0));
			tag_s[0] <= tag;
			for (int j = 1; j < STEPS; j++) begin
				rem_s[j] <= rem_nx[j-1];
				dv_s[j]  <= dv_s[j-1];
				quo_s[j] <= quo_nx[j-1];
				neg_s[j] <= neg_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
				tag_s[j] <= tag_s[j-1];
			end
			// saturate and restore sign
			if (ovf_s[STEPS-1] || qfin[QW-1]) begin
				quo <= neg_s[STEPS-1] ? -gmec_pkg::SATQ : gmec_pkg::SATQ;
			end else begin
				quo <= neg_s[STEPS-1] ? -gmec_pkg::q_t'(qfin) : gmec_pkg::q_t'(qfin);
			end
			quo_tag <= tag_s[STEPS-1];
		end
	end

endmodule

// ----- design/gmec_qmul.sv -----
module gmec_qmul #(
	parameter int TAG_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                start,
	input  gmec_pkg::q_t        a,
	input  gmec_pkg::q_t        b,
	input  logic [TAG_W-1:0]    tag,
	output logic                prod_valid,
	output gmec_pkg::q_t        prod,
	output logic [TAG_W-1:0]    prod_tag
);

	localparam int QW = gmec_pkg::QW;
	localparam int DW = gmec_pkg::DW;
	localparam int IFB = gmec_pkg::IFB;
	localparam int HW = DW + DW - IFB;
	localparam int LW = DW + IFB;

	logic [DW-1:0] ma;
	logic [DW-1:0] mb;
	logic [HW-1:0] hi_s1;
	logic [LW-1:0] lo_s1;
	logic neg_s1;
	logic vld_s1;
	logic [TAG_W-1:0] tag_s1;
	logic [HW:0] msum;

	assign ma = gmec_pkg::mag(a);
	assign mb = gmec_pkg::mag(b);
	assign msum = (HW+1)'(hi_s1) + (HW+1)'(lo_s1[LW-1:IFB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			prod_valid <= 1'b0;
		end else if (en) begin
			vld_s1 <= start;
			prod_valid <= vld_s1;
		end
	end

	// partial products, then sum truncated toward zero with saturation
	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1 <= HW'(ma) * HW'(mb[DW-1:IFB]);
			lo_s1 <= LW'(ma) * LW'(mb[IFB-1:0]);
			neg_s1 <= a[QW-1] ^ b[QW-1];
			tag_s1 <= tag;
			if (msum > (HW+1)'(gmec_pkg::SATQ)) begin
				prod <= neg_s1 ? -gmec_pkg::SATQ : gmec_pkg::SATQ;
			end else begin
				prod <= neg_s1 ? -gmec_pkg::q_t'(msum) : gmec_pkg::q_t'(msum);
			end
			prod_tag <= tag_s1;
		end
	end

endmodule

// ----- design/gmec_lane.sv -----
module gmec_lane #(
	parameter int GAS = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            start,
	input  gmec_pkg::q_t    alpha,
	input  gmec_pkg::q_t    bnum,
	input  gmec_pkg::q_t    pt,
	input  gmec_pkg::q_t    o2,
	input  gmec_pkg::q_t    gas,
	input  logic            flt,
	output logic            term_valid,
	output gmec_pkg::q_t    term_x,
	output gmec_pkg::q_t    term_y,
	output logic            term_fault
);

	typedef struct packed {
		gmec_pkg::q_t alpha;
		gmec_pkg::q_t pt;
		gmec_pkg::q_t gas;
		gmec_pkg::wide_t px;
		gmec_pkg::wide_t py;
		logic flt;
	} btag_t;

	typedef struct packed {
		gmec_pkg::q_t pt;
		gmec_pkg::q_t gas;
		gmec_pkg::wide_t px;
		gmec_pkg::wide_t py;
		logic flt;
	} mtag_t;

	typedef struct packed {
		gmec_pkg::q_t pt;
		logic flt;
	} ttag_t;

	logic vld_s1;
	gmec_pkg::q_t den_s1;
	gmec_pkg::q_t alpha_s1;
	gmec_pkg::q_t bnum_s1;
	gmec_pkg::q_t pt_s1;
	gmec_pkg::q_t gas_s1;
	gmec_pkg::wide_t px_s1;
	gmec_pkg::wide_t py_s1;
	logic flt_s1;

	btag_t btag;
	btag_t beta_tag;
	logic beta_valid;
	gmec_pkg::q_t beta_raw;
	gmec_pkg::q_t beta;

	mtag_t mtag;
	mtag_t ab_tag;
	logic ab_valid;
	gmec_pkg::q_t ab;

	logic vld_s3;
	gmec_pkg::q_t bx_s3;
	gmec_pkg::q_t by_s3;
	gmec_pkg::q_t pt_s3;
	gmec_pkg::q_t gas_s3;
	logic flt_s3;

	ttag_t ttag;
	ttag_t qx_tag;
	ttag_t qy_tag;
	logic qx_valid;
	logic qy_valid;
	gmec_pkg::q_t qx;
	gmec_pkg::q_t qy;
	logic fx;
	logic fy;
	logic dx_valid;
	logic dy_valid;

	// divisor and the beta-independent parts of the brackets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= start;
			vld_s3 <= ab_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s1 <= gmec_pkg::sat(gmec_pkg::wide_t'(gmec_pkg::CQ_A[GAS])
				- gmec_pkg::wide_t'(gmec_pkg::kmul(alpha, gmec_pkg::KC_B[GAS])));
			px_s1 <= gmec_pkg::wide_t'(gmec_pkg::CQ_XC[GAS])
				+ gmec_pkg::wide_t'(gmec_pkg::kmul(pt, gmec_pkg::KC_XD[GAS]))
				+ gmec_pkg::wide_t'(gmec_pkg::kmul(o2, gmec_pkg::KC_XE[GAS]));
			py_s1 <= gmec_pkg::wide_t'(gmec_pkg::CQ_YC[GAS])
				+ gmec_pkg::wide_t'(gmec_pkg::kmul(pt, gmec_pkg::KC_YD[GAS]))
				+ gmec_pkg::wide_t'(gmec_pkg::kmul(o2, gmec_pkg::KC_YE[GAS]));
			alpha_s1 <= alpha;
			bnum_s1 <= bnum;
			pt_s1 <= pt;
			gas_s1 <= gas;
			flt_s1 <= flt;
		end
	end

	// beta = bnum / den
	assign btag = '{alpha: alpha_s1, pt: pt_s1, gas: gas_s1, px: px_s1, py: py_s1,
		flt: flt_s1 | (den_s1 == '0)};

	gmec_div #(.TAG_W($bits(btag_t))) u_beta_div (
		.clk(clk), .arst_n(arst_n), .en(en), .start(vld_s1),
		.num(bnum_s1), .den(den_s1), .tag(btag),
		.quo_valid(beta_valid), .quo(beta_raw), .quo_tag(beta_tag)
	);

	// clamp beta at one, then alpha*beta
	assign beta = (beta_raw > gmec_pkg::ONEQ) ? gmec_pkg::ONEQ : beta_raw;
	assign mtag = '{pt: beta_tag.pt, gas: beta_tag.gas, px: beta_tag.px, py: beta_tag.py,
		flt: beta_tag.flt};

	gmec_qmul #(.TAG_W($bits(mtag_t))) u_ab_mul (
		.clk(clk), .arst_n(arst_n), .en(en), .start(beta_valid),
		.a(beta_tag.alpha), .b(beta), .tag(mtag),
		.prod_valid(ab_valid), .prod(ab), .prod_tag(ab_tag)
	);

	// finish the brackets
	always_ff @(posedge clk) begin
		if (en) begin
			bx_s3 <= gmec_pkg::sat(ab_tag.px
				+ gmec_pkg::wide_t'(gmec_pkg::kmul(ab, gmec_pkg::KC_XF[GAS])));
			by_s3 <= gmec_pkg::sat(ab_tag.py
				+ gmec_pkg::wide_t'(gmec_pkg::kmul(ab, gmec_pkg::KC_YF[GAS])));
			pt_s3 <= ab_tag.pt;
			gas_s3 <= ab_tag.gas;
			flt_s3 <= ab_tag.flt;
		end
	end

	assign ttag = '{pt: pt_s3, flt: flt_s3};

	// bracket times gas percentage
	gmec_qmul #(.TAG_W($bits(ttag_t))) u_x_mul (
		.clk(clk), .arst_n(arst_n), .en(en), .start(vld_s3),
		.a(bx_s3), .b(gas_s3), .tag(ttag),
		.prod_valid(qx_valid), .prod(qx), .prod_tag(qx_tag)
	);

	gmec_qmul #(.TAG_W($bits(ttag_t))) u_y_mul (
		.clk(clk), .arst_n(arst_n), .en(en), .start(vld_s3),
		.a(by_s3), .b(gas_s3), .tag(ttag),
		.prod_valid(qy_valid), .prod(qy), .prod_tag(qy_tag)
	);

	// divide by the combustible total
	gmec_div #(.TAG_W(1)) u_x_div (
		.clk(clk), .arst_n(arst_n), .en(en), .start(qx_valid),
		.num(qx), .den(qx_tag.pt), .tag(qx_tag.flt),
		.quo_valid(dx_valid), .quo(term_x), .quo_tag(fx)
	);

	gmec_div #(.TAG_W(1)) u_y_div (
		.clk(clk), .arst_n(arst_n), .en(en), .start(qy_valid),
		.num(qy), .den(qy_tag.pt), .tag(qy_tag.flt),
		.quo_valid(dy_valid), .quo(term_y), .quo_tag(fy)
	);

	assign term_valid = dx_valid & dy_valid;
	assign term_fault = fx | fy;

endmodule

// ----- design/gmec_merge.sv -----
module gmec_merge #(
	parameter int FRAC_BITS = gmec_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                start,
	input  gmec_pkg::q_t        term_x [gmec_pkg::NGAS],
	input  gmec_pkg::q_t        term_y [gmec_pkg::NGAS],
	input  logic [gmec_pkg::NGAS-1:0] term_fault,
	output logic                verdict_valid,
	output gmec_pkg::verdict_t  verdict
);

	localparam int SH = gmec_pkg::IFB - FRAC_BITS;
	localparam int OW = gmec_pkg::OW;
	localparam longint ONE = longint'(1) <<< gmec_pkg::IFB;
	localparam gmec_pkg::q_t OMAX = gmec_pkg::q_t'((longint'(1) <<< (OW - 1)) - 1);
	localparam gmec_pkg::q_t OMIN = -gmec_pkg::q_t'(longint'(1) <<< (OW - 1));

	logic vld_s1;
	gmec_pkg::q_t x_s1;
	gmec_pkg::q_t y_s1;
	logic flt_s1;
	gmec_pkg::q_t xacc;
	gmec_pkg::q_t yacc;

	longint x100, y100, ya, xb;
	logic in_x, below3, above, boom;

	function automatic logic signed [OW-1:0] to_out(gmec_pkg::q_t v);
		gmec_pkg::q_t r;
		r = v >>> SH;
		if (r > OMAX) begin
			r = OMAX;
		end else if (r < OMIN) begin
			r = OMIN;
		end
		return r[OW-1:0];
	endfunction

	// saturating accumulation in lane order
	always_comb begin
		xacc = '0;
		yacc = '0;
		for (int i = 0; i < gmec_pkg::NGAS; i++) begin
			xacc = gmec_pkg::sat(gmec_pkg::wide_t'(xacc) + gmec_pkg::wide_t'(term_x[i]));
			yacc = gmec_pkg::sat(gmec_pkg::wide_t'(yacc) + gmec_pkg::wide_t'(term_y[i]));
		end
	end

	// triangle test on scaled coordinates
	always_comb begin
		x100 = 100 * longint'(x_s1);
		y100 = 100 * longint'(y_s1);
		ya = y100 - 1988 * ONE;
		xb = x100 - 500 * ONE;
		in_x = (x100 >= 500 * ONE) && (x100 <= 1500 * ONE);
		below3 = (1000 * ya) <= (-209 * xb);
		if (x100 <= 518 * ONE) begin
			above = (18 * ya + 1041 * xb) >= 0;
		end else begin
			above = (982 * (y100 - 1779 * ONE)) >= (832 * (x100 - 1500 * ONE));
		end
		boom = !flt_s1 && in_x && above && below3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			verdict_valid <= 1'b0;
		end else if (en) begin
			vld_s1 <= start;
			verdict_valid <= vld_s1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= xacc;
			y_s1 <= yacc;
			flt_s1 <= |term_fault;
			verdict.explosive <= boom;
			verdict.x_coord <= flt_s1 ? '0 : to_out(x_s1);
			verdict.y_coord <= flt_s1 ? '0 : to_out(y_s1);
			verdict.fault <= flt_s1;
		end
	end

endmodule
